### hw/rtl/qrs_pkg.sv
// Package for the quadratic root solver: default word sizes, status codes and
// the flag group that travels down the pipeline. No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

	localparam int QRS_WORD_BITS = 32;
	localparam int QRS_FRAC_BITS = 16;

	localparam int STATUS_BITS = 2;

	localparam logic [STATUS_BITS-1:0] ST_REAL  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_CPLX  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_AZERO = 2'd2;

	// Per-item flags carried alongside the data.
	typedef struct packed {
		logic azero;
		logic dneg;
	} qrs_flags_t;

	localparam int FLAGS_BITS = $bits(qrs_flags_t);

endpackage

### hw/rtl/qrs_in_if.sv
// Coefficient channel of the quadratic root solver.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

interface qrs_in_if
	import qrs_pkg::*;
	#(parameter int WORD_BITS = QRS_WORD_BITS);

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] coef_a;
	logic signed [WORD_BITS-1:0] coef_b;
	logic signed [WORD_BITS-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);

endinterface

### hw/rtl/qrs_out_if.sv
// Root channel of the quadratic root solver.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

interface qrs_out_if
	import qrs_pkg::*;
	#(parameter int WORD_BITS = QRS_WORD_BITS);

	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] first_real;
	logic signed [WORD_BITS-1:0] second_real;
	logic signed [WORD_BITS-1:0] first_imag;
	logic signed [WORD_BITS-1:0] second_imag;
	logic [STATUS_BITS-1:0]      status;
	logic                        saturated;

	modport source (output valid, first_real, second_real, first_imag, second_imag,
		status, saturated, input ready);
	modport sink   (input valid, first_real, second_real, first_imag, second_imag,
		status, saturated, output ready);

endinterface

### hw/rtl/qrs_front.sv
// Front end: coefficient magnitudes, the two products and the discriminant.
// Three register stages. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	localparam int DW = 2 * WORD_BITS + 1
	) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	input  logic signed [WORD_BITS-1:0] c,
	output logic                        out_valid,
	output logic [DW-1:0]               disc,
	output logic [WORD_BITS-1:0]        ma,
	output logic [WORD_BITS-1:0]        mb,
	output logic                        na,
	output logic                        nb,
	output qrs_flags_t                  flags
	);

	localparam int W = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int XW = PW + 2;

	logic         v_s1, v_s2, v_s3;
	logic [W-1:0] ma_s1, mb_s1, mc_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	logic         na_s1, nb_s1, nc_s1, az_s1, na_s2, nb_s2, az_s2, acneg_s2;
	logic         na_s3, nb_s3, az_s3, dneg_s3;
	logic [PW-1:0] b2_s2, ac_s2;
	logic [DW-1:0] disc_s3;

	logic [XW-1:0] b2_x, ac4_x, disc_x;
	logic          b2_ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		b2_x   = XW'(b2_s2);
		ac4_x  = {ac_s2, 2'b00};
		b2_ge  = b2_x >= ac4_x;
		if (acneg_s2) begin
			disc_x = b2_x + ac4_x;
		end else if (b2_ge) begin
			disc_x = b2_x - ac4_x;
		end else begin
			disc_x = ac4_x - b2_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s1 <= a[W-1];
			nb_s1 <= b[W-1];
			nc_s1 <= c[W-1];
			ma_s1 <= a[W-1] ? W'(-a) : W'(a);
			mb_s1 <= b[W-1] ? W'(-b) : W'(b);
			mc_s1 <= c[W-1] ? W'(-c) : W'(c);
			az_s1 <= a == '0;

			b2_s2    <= mb_s1 * mb_s1;
			ac_s2    <= ma_s1 * mc_s1;
			acneg_s2 <= (na_s1 != nc_s1) && (mc_s1 != '0);
			ma_s2    <= ma_s1;
			mb_s2    <= mb_s1;
			na_s2    <= na_s1;
			nb_s2    <= nb_s1;
			az_s2    <= az_s1;

			disc_s3 <= disc_x[DW-1:0];
			dneg_s3 <= !acneg_s2 && !b2_ge;
			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
			na_s3   <= na_s2;
			nb_s3   <= nb_s2;
			az_s3   <= az_s2;
		end
	end

	assign out_valid   = v_s3;
	assign disc        = disc_s3;
	assign ma          = ma_s3;
	assign mb          = mb_s3;
	assign na          = na_s3;
	assign nb          = nb_s3;
	assign flags.azero = az_s3;
	assign flags.dneg  = dneg_s3;

endmodule

### hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage, of disc * 2^(2F).
// Carries an opaque sideband word alongside. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	parameter int FRAC_BITS = QRS_FRAC_BITS,
	parameter int SBW = 1,
	localparam int DW  = 2 * WORD_BITS + 1,
	localparam int RTW = WORD_BITS + FRAC_BITS + 1
	) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [DW-1:0]  disc,
	input  logic [SBW-1:0] sb_in,
	output logic           out_valid,
	output logic [RTW-1:0] root,
	output logic [SBW-1:0] sb_out
	);

	localparam int RW  = 2 * RTW;
	localparam int RMW = RTW + 2;

	logic [RMW-1:0] rem_s  [RTW];
	logic [RTW-1:0] root_s [RTW];
	logic [RW-1:0]  rad_s  [RTW];
	logic [SBW-1:0] sb_s   [RTW];
	logic           v_s    [RTW];

	for (genvar i = 0; i < RTW; i++) begin : g_stage
		logic [RMW-1:0] rem_i, rem_sh, trial, rem_n;
		logic [RTW-1:0] root_i;
		logic [RW-1:0]  rad_i;
		logic [SBW-1:0] sb_i;
		logic           v_i, ge;

		if (i == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = {1'b0, disc, {(2 * FRAC_BITS){1'b0}}};
			assign sb_i   = sb_in;
			assign v_i    = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
			assign rad_i  = rad_s[i-1];
			assign sb_i   = sb_s[i-1];
			assign v_i    = v_s[i-1];
		end

		always_comb begin
			rem_sh = {rem_i[RMW-3:0], rad_i[RW-1 -: 2]};
			trial  = {root_i, 2'b01};
			ge     = rem_sh >= trial;
			rem_n  = ge ? rem_sh - trial : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= rem_n;
				root_s[i] <= {root_i[RTW-2:0], ge};
				rad_s[i]  <= {rad_i[RW-3:0], 2'b00};
				sb_s[i]   <= sb_i;
			end
		end
	end

	assign out_valid = v_s[RTW-1];
	assign root      = root_s[RTW-1];
	assign sb_out    = sb_s[RTW-1];

endmodule

### hw/rtl/qrs_mid.sv
// Forms the two dividend magnitudes, their signs and the divisor 2|a|.
// One register stage. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_mid
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	parameter int FRAC_BITS = QRS_FRAC_BITS,
	localparam int RTW = WORD_BITS + FRAC_BITS + 1,
	localparam int NW  = WORD_BITS + FRAC_BITS + 2
	) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [RTW-1:0]       root,
	input  logic [WORD_BITS-1:0] ma,
	input  logic [WORD_BITS-1:0] mb,
	input  logic                 na,
	input  logic                 nb,
	input  qrs_flags_t           flags_in,
	output logic                 out_valid,
	output logic [NW-1:0]        num0,
	output logic [NW-1:0]        num1,
	output logic                 neg0,
	output logic                 neg1,
	output logic [WORD_BITS:0]   den,
	output qrs_flags_t           flags_out
	);

	logic [NW-1:0] mb_sh, root_x, sum, diff, n0, n1;
	logic          ge, g0, g1;

	logic          v_s1, neg0_s1, neg1_s1;
	logic [NW-1:0] num0_s1, num1_s1;
	logic [WORD_BITS:0] den_s1;
	qrs_flags_t    flags_s1;

	always_comb begin
		mb_sh  = NW'(mb) << FRAC_BITS;
		root_x = NW'(root);
		sum    = mb_sh + root_x;
		ge     = mb_sh >= root_x;
		diff   = ge ? mb_sh - root_x : root_x - mb_sh;
		if (flags_in.dneg) begin
			// Complex pair: real part from -b, imaginary part from the root.
			n0 = mb_sh;
			g0 = !nb;
			n1 = root_x;
			g1 = 1'b0;
		end else if (nb) begin
			n0 = sum;
			g0 = 1'b0;
			n1 = diff;
			g1 = !ge;
		end else begin
			n0 = diff;
			g0 = ge;
			n1 = sum;
			g1 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s1  <= n0;
			num1_s1  <= n1;
			neg0_s1  <= g0 ^ na;
			neg1_s1  <= g1 ^ na;
			den_s1   <= {ma, 1'b0};
			flags_s1 <= flags_in;
		end
	end

	assign out_valid = v_s1;
	assign num0      = num0_s1;
	assign num1      = num1_s1;
	assign neg0      = neg0_s1;
	assign neg1      = neg1_s1;
	assign den       = den_s1;
	assign flags_out = flags_s1;

endmodule

### hw/rtl/qrs_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage. Carries an opaque sideband word. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	parameter int FRAC_BITS = QRS_FRAC_BITS,
	parameter int SBW = 1,
	localparam int NW = WORD_BITS + FRAC_BITS + 2
	) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [NW-1:0]      num0,
	input  logic [NW-1:0]      num1,
	input  logic [WORD_BITS:0] den,
	input  logic [SBW-1:0]     sb_in,
	output logic               out_valid,
	output logic [NW-1:0]      quot0,
	output logic [NW-1:0]      quot1,
	output logic [SBW-1:0]     sb_out
	);

	localparam int DRW = WORD_BITS + 2;

	logic [DRW-1:0]     rem0_s [NW];
	logic [DRW-1:0]     rem1_s [NW];
	logic [NW-1:0]      num0_s [NW];
	logic [NW-1:0]      num1_s [NW];
	logic [NW-1:0]      q0_s   [NW];
	logic [NW-1:0]      q1_s   [NW];
	logic [WORD_BITS:0] den_s  [NW];
	logic [SBW-1:0]     sb_s   [NW];
	logic               v_s    [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DRW-1:0]     r0_i, r1_i, rs0, rs1, dx;
		logic [NW-1:0]      n0_i, n1_i, q0_i, q1_i;
		logic [WORD_BITS:0] d_i;
		logic [SBW-1:0]     sb_i;
		logic               v_i, ge0, ge1;

		if (i == 0) begin : g_first
			assign r0_i = '0;
			assign r1_i = '0;
			assign n0_i = num0;
			assign n1_i = num1;
			assign q0_i = '0;
			assign q1_i = '0;
			assign d_i  = den;
			assign sb_i = sb_in;
			assign v_i  = in_valid;
		end else begin : g_next
			assign r0_i = rem0_s[i-1];
			assign r1_i = rem1_s[i-1];
			assign n0_i = num0_s[i-1];
			assign n1_i = num1_s[i-1];
			assign q0_i = q0_s[i-1];
			assign q1_i = q1_s[i-1];
			assign d_i  = den_s[i-1];
			assign sb_i = sb_s[i-1];
			assign v_i  = v_s[i-1];
		end

		always_comb begin
			dx  = DRW'(d_i);
			rs0 = {r0_i[DRW-2:0], n0_i[NW-1]};
			rs1 = {r1_i[DRW-2:0], n1_i[NW-1]};
			ge0 = rs0 >= dx;
			ge1 = rs1 >= dx;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem0_s[i] <= ge0 ? rs0 - dx : rs0;
				rem1_s[i] <= ge1 ? rs1 - dx : rs1;
				num0_s[i] <= {n0_i[NW-2:0], 1'b0};
				num1_s[i] <= {n1_i[NW-2:0], 1'b0};
				q0_s[i]   <= {q0_i[NW-2:0], ge0};
				q1_s[i]   <= {q1_i[NW-2:0], ge1};
				den_s[i]  <= d_i;
				sb_s[i]   <= sb_i;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quot0     = q0_s[NW-1];
	assign quot1     = q1_s[NW-1];
	assign sb_out    = sb_s[NW-1];

endmodule

### hw/rtl/qrs_back.sv
// Output stage: applies signs, saturates to the word and registers the result.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_back
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	parameter int FRAC_BITS = QRS_FRAC_BITS,
	localparam int NW = WORD_BITS + FRAC_BITS + 2
	) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [NW-1:0]               quot0,
	input  logic [NW-1:0]               quot1,
	input  logic                        neg0,
	input  logic                        neg1,
	input  qrs_flags_t                  flags,
	output logic                        out_valid,
	output logic signed [WORD_BITS-1:0] first_real,
	output logic signed [WORD_BITS-1:0] second_real,
	output logic signed [WORD_BITS-1:0] first_imag,
	output logic signed [WORD_BITS-1:0] second_imag,
	output logic [STATUS_BITS-1:0]      status,
	output logic                        saturated
	);

	localparam int W = WORD_BITS;
	localparam logic [NW-1:0] LIM  = NW'(1) << (W - 1);
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

	// Returns {clipped, value}.
	function automatic logic [W:0] sat_word(input logic [NW-1:0] q, input logic neg);
		logic [W:0] r;
		if (neg) begin
			r = (q > LIM) ? {1'b1, MINV} : {1'b0, W'(-q[W-1:0])};
		end else begin
			r = (q >= LIM) ? {1'b1, MAXV} : {1'b0, q[W-1:0]};
		end
		return r;
	endfunction

	logic [W:0] r0, r1, r1n;
	logic [W-1:0] fr, sr, fi, si;
	logic [STATUS_BITS-1:0] st;
	logic sat;

	logic v_q, sat_q;
	logic [W-1:0] fr_q, sr_q, fi_q, si_q;
	logic [STATUS_BITS-1:0] st_q;

	always_comb begin
		r0  = sat_word(quot0, neg0);
		r1  = sat_word(quot1, neg1);
		r1n = sat_word(quot1, !neg1);
		if (flags.azero) begin
			fr  = '0;
			sr  = '0;
			fi  = '0;
			si  = '0;
			st  = ST_AZERO;
			sat = 1'b0;
		end else if (flags.dneg) begin
			fr  = r0[W-1:0];
			sr  = r0[W-1:0];
			fi  = r1[W-1:0];
			si  = r1n[W-1:0];
			st  = ST_CPLX;
			sat = r0[W] | r1[W] | r1n[W];
		end else begin
			fr  = r0[W-1:0];
			sr  = r1[W-1:0];
			fi  = '0;
			si  = '0;
			st  = ST_REAL;
			sat = r0[W] | r1[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_q  <= fr;
			sr_q  <= sr;
			fi_q  <= fi;
			si_q  <= si;
			st_q  <= st;
			sat_q <= sat;
		end
	end

	assign out_valid   = v_q;
	assign first_real  = fr_q;
	assign second_real = sr_q;
	assign first_imag  = fi_q;
	assign second_imag = si_q;
	assign status      = st_q;
	assign saturated   = sat_q;

endmodule

### hw/rtl/quadratic_root_solver_top.sv
// Quadratic root solver top level: front end, square root, dividend set-up,
// divider and output stage. Depends on qrs_pkg and the two channel interfaces.
//
//   channel  modport  beat carries
//   coef     sink     coef_a, coef_b, coef_c (signed Q16.16)
//   roots    source   four root parts, status, saturated
//
// One beat in per cycle while no result waits on roots. The stages run in
// order: three front stages, one stage per square-root bit, one set-up stage,
// one stage per quotient bit and the output register.
// Reset clears every valid bit; the data registers are not reset.
// The whole pipeline holds while a result waits on roots, so nothing is lost.
`timescale 1ns / 1ps

module quadratic_root_solver_top
	import qrs_pkg::*;
	#(
	parameter int WORD_BITS = QRS_WORD_BITS,
	parameter int FRAC_BITS = QRS_FRAC_BITS
	) (
	input  logic     clk,
	input  logic     arst_n,
	qrs_in_if.sink   coef,
	qrs_out_if.source roots
	);

	localparam int W   = WORD_BITS;
	localparam int DW  = 2 * W + 1;
	localparam int RTW = W + FRAC_BITS + 1;
	localparam int NW  = W + FRAC_BITS + 2;
	localparam int SB1 = FLAGS_BITS + 2 * W + 2;
	localparam int SB2 = FLAGS_BITS + 2;

	logic en;

	logic           fe_v, fe_na, fe_nb;
	logic [DW-1:0]  fe_disc;
	logic [W-1:0]   fe_ma, fe_mb;
	qrs_flags_t     fe_flags;

	logic           sq_v;
	logic [RTW-1:0] sq_root;
	logic [SB1-1:0] sq_sb;

	logic           md_v, md_neg0, md_neg1;
	logic [NW-1:0]  md_num0, md_num1;
	logic [W:0]     md_den;
	qrs_flags_t     md_flags;

	logic           dv_v;
	logic [NW-1:0]  dv_q0, dv_q1;
	logic [SB2-1:0] dv_sb;

	assign en         = !roots.valid || roots.ready;
	assign coef.ready = en;

	qrs_front #(.WORD_BITS(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(coef.valid), .a(coef.coef_a), .b(coef.coef_b), .c(coef.coef_c),
		.out_valid(fe_v), .disc(fe_disc), .ma(fe_ma), .mb(fe_mb),
		.na(fe_na), .nb(fe_nb), .flags(fe_flags)
	);

	qrs_sqrt #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SBW(SB1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(fe_v), .disc(fe_disc),
		.sb_in({fe_flags, fe_ma, fe_mb, fe_na, fe_nb}),
		.out_valid(sq_v), .root(sq_root), .sb_out(sq_sb)
	);

	qrs_mid #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mid (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_v), .root(sq_root),
		.ma(sq_sb[2*W+1 -: W]), .mb(sq_sb[W+1 -: W]),
		.na(sq_sb[1]), .nb(sq_sb[0]),
		.flags_in(qrs_flags_t'(sq_sb[SB1-1 -: FLAGS_BITS])),
		.out_valid(md_v), .num0(md_num0), .num1(md_num1),
		.neg0(md_neg0), .neg1(md_neg1), .den(md_den), .flags_out(md_flags)
	);

	qrs_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SBW(SB2)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(md_v), .num0(md_num0), .num1(md_num1), .den(md_den),
		.sb_in({md_flags, md_neg0, md_neg1}),
		.out_valid(dv_v), .quot0(dv_q0), .quot1(dv_q1), .sb_out(dv_sb)
	);

	qrs_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dv_v), .quot0(dv_q0), .quot1(dv_q1),
		.neg0(dv_sb[1]), .neg1(dv_sb[0]),
		.flags(qrs_flags_t'(dv_sb[SB2-1 -: FLAGS_BITS])),
		.out_valid(roots.valid),
		.first_real(roots.first_real), .second_real(roots.second_real),
		.first_imag(roots.first_imag), .second_imag(roots.second_imag),
		.status(roots.status), .saturated(roots.saturated)
	);

	a_azero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && roots.status == ST_AZERO |->
		roots.first_real == '0 && roots.second_real == '0 &&
		roots.first_imag == '0 && roots.second_imag == '0 && !roots.saturated)
		else $error("zero-a result carries non-zero parts");

	a_real_no_imag: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && roots.status == ST_REAL |->
		roots.first_imag == '0 && roots.second_imag == '0)
		else $error("real roots with an imaginary part");

	a_cplx_shared_real: assert property (@(posedge clk) disable iff (!arst_n)
		roots.valid && roots.status == ST_CPLX |->
		roots.first_real == roots.second_real)
		else $error("complex pair with differing real parts");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!coef.ready |-> roots.valid && !roots.ready)
		else $error("input held off without a blocked result");

endmodule
